/* hdl/tsm_pkg.sv */
// Package for the time sync message monitor.
// Holds character codes, sync and register codes, shared structs and the digit decoder.
// No dependencies.
package tsm_pkg;

   localparam int MESSAGE_BYTES_DEF = 20;

   localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
   localparam logic [7:0] CHAR_G_UPPER = 8'h47;
   localparam logic [7:0] CHAR_G_LOWER = 8'h67;
   localparam logic [7:0] CHAR_P_UPPER = 8'h50;
   localparam logic [7:0] CHAR_P_LOWER = 8'h70;
   localparam logic [7:0] CHAR_S_UPPER = 8'h53;
   localparam logic [7:0] CHAR_S_LOWER = 8'h73;
   localparam logic [7:0] CHAR_A_UPPER = 8'h41;
   localparam logic [7:0] CHAR_ONE     = 8'h31;
   localparam logic [7:0] ASCII_ZERO   = 8'd48;
   localparam logic [7:0] SECOND_LIMIT = 8'd56;

   localparam logic [7:0] SAVE_RELOAD_RST      = 8'd60;
   localparam logic [7:0] SAVE_READY_LEVEL_RST = 8'd0;
   localparam logic [7:0] LINK_RELOAD_RST      = 8'd10;
   localparam logic       LINK_IDLE_RST        = 1'b0;

   localparam int CSR_DATA_W = 8;

   typedef enum logic [1:0] {
      SYNC_RED   = 2'd0,
      SYNC_GREEN = 2'd1,
      SYNC_BOTH  = 2'd2
   } sync_type;

   typedef enum logic [1:0] {
      CSR_SAVE_RELOAD      = 2'd0,
      CSR_SAVE_READY_LEVEL = 2'd1,
      CSR_LINK_RELOAD      = 2'd2,
      CSR_LINK_IDLE        = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] save_reload;
      logic [7:0] save_ready_level;
      logic [7:0] link_timeout_reload;
      logic       link_idle_value;
   } cfg_type;

   typedef struct packed {
      logic       header_ok;
      logic [3:0] health;
      logic [7:0] hour;
      logic [7:0] minute;
      logic [7:0] second;
      logic [7:0] day;
      logic [7:0] month;
      logic [7:0] year;
   } msg_type;

   typedef struct packed {
      sync_type   lock_state;
      logic       link_up;
      logic       message_ok;
      logic [3:0] health_flags;
      logic       rtc_write;
      logic [7:0] hour_value;
      logic [7:0] minute_value;
      logic [7:0] second_value;
      logic [7:0] day_value;
      logic [7:0] month_value;
      logic [7:0] year_value;
   } rsp_type;

   function automatic logic [7:0] two_digits(input logic [7:0] tens_char,
                                             input logic [7:0] units_char);
      logic [7:0] tens;
      logic [7:0] units;
      tens  = tens_char - ASCII_ZERO;
      units = units_char - ASCII_ZERO;
      return (tens << 3) + (tens << 1) + units;
   endfunction

endpackage

/* hdl/tsm_store.sv */
// Message byte store and write position for the time sync message monitor.
// Merges the current byte, checks the header and decodes time and health fields.
// Depends on tsm_pkg.
module tsm_store #(
   parameter int MESSAGE_BYTES = tsm_pkg::MESSAGE_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic             op,
   input  logic [7:0]       msg_byte,
   input  logic             msg_last,
   output tsm_pkg::msg_type msg
);
   import tsm_pkg::*;

   localparam int POS_W = $clog2(MESSAGE_BYTES + 1);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       store_ff [MESSAGE_BYTES];
   logic [7:0]       store_in [MESSAGE_BYTES];
   logic [7:0]       view     [MESSAGE_BYTES];

   always_comb begin
      for (int i = 0; i < MESSAGE_BYTES; i++) begin
         view[i] = (pos_ff == POS_W'(i)) ? msg_byte : store_ff[i];
      end
   end

   always_comb begin
      pos_in = pos_ff;
      for (int i = 0; i < MESSAGE_BYTES; i++) begin
         store_in[i] = store_ff[i];
      end
      if (step && !op) begin
         if (msg_last) begin
            pos_in = '0;
            for (int i = 0; i < MESSAGE_BYTES; i++) begin
               store_in[i] = '0;
            end
         end else begin
            for (int i = 0; i < MESSAGE_BYTES; i++) begin
               store_in[i] = view[i];
            end
            if (pos_ff != POS_W'(MESSAGE_BYTES)) begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         for (int i = 0; i < MESSAGE_BYTES; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         pos_ff <= pos_in;
         for (int i = 0; i < MESSAGE_BYTES; i++) begin
            store_ff[i] <= store_in[i];
         end
      end
   end

   always_comb begin
      msg.header_ok = (view[0] == CHAR_DOLLAR) &&
                      (view[1] == CHAR_G_UPPER || view[1] == CHAR_G_LOWER) &&
                      (view[2] == CHAR_P_UPPER || view[2] == CHAR_P_LOWER) &&
                      (view[3] == CHAR_S_UPPER || view[3] == CHAR_S_LOWER);
      msg.health    = {view[19] == CHAR_ONE, view[18] == CHAR_ONE,
                       view[17] == CHAR_A_UPPER, view[16] == CHAR_A_UPPER};
      msg.hour      = two_digits(view[4], view[5]);
      msg.minute    = two_digits(view[6], view[7]);
      msg.second    = two_digits(view[8], view[9]);
      msg.day       = two_digits(view[10], view[11]);
      msg.month     = two_digits(view[12], view[13]);
      msg.year      = two_digits(view[14], view[15]);
   end

endmodule

/* hdl/tsm_core.sv */
// Sync, link and save countdown state of the time sync message monitor.
// Applies ticks and completed messages and forms the result item.
// Depends on tsm_pkg.
module tsm_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic             op,
   input  logic             msg_last,
   input  tsm_pkg::msg_type msg,
   input  tsm_pkg::cfg_type cfg,
   output tsm_pkg::rsp_type rsp
);
   import tsm_pkg::*;

   logic [7:0] save_cd_ff, save_cd_in;
   logic [7:0] link_cd_ff, link_cd_in;
   logic [7:0] link_cd_dec;
   sync_type   status_ff, status_in;
   logic       link_ff, link_in;
   logic [3:0] health_ff, health_in;
   logic       msg_ok;
   logic       rtc;

   always_comb begin
      save_cd_in  = save_cd_ff;
      link_cd_in  = link_cd_ff;
      status_in   = status_ff;
      link_in     = link_ff;
      health_in   = health_ff;
      msg_ok      = 1'b0;
      rtc         = 1'b0;
      link_cd_dec = (link_cd_ff > 8'd1) ? link_cd_ff - 8'd1 : link_cd_ff;
      if (op) begin
         if (save_cd_ff > cfg.save_ready_level) begin
            save_cd_in = save_cd_ff - 8'd1;
         end
         if (link_cd_dec == 8'd1) begin
            status_in  = SYNC_RED;
            link_cd_in = {7'd0, cfg.link_idle_value};
            link_in    = 1'b0;
         end else begin
            link_cd_in = link_cd_dec;
         end
      end else if (msg_last && msg.header_ok) begin
         msg_ok = 1'b1;
         if (save_cd_ff == cfg.save_ready_level) begin
            save_cd_in = cfg.save_reload;
            rtc        = (msg.second < SECOND_LIMIT);
         end
         status_in  = (msg.health[0] || msg.health[1]) ? SYNC_GREEN : SYNC_BOTH;
         link_cd_in = cfg.link_timeout_reload;
         link_in    = 1'b1;
         health_in  = msg.health;
      end
   end

   always_comb begin
      rsp.lock_state   = status_in;
      rsp.link_up      = link_in;
      rsp.message_ok   = msg_ok;
      rsp.health_flags = health_in;
      rsp.rtc_write    = rtc;
      rsp.hour_value   = msg_ok ? msg.hour   : 8'd0;
      rsp.minute_value = msg_ok ? msg.minute : 8'd0;
      rsp.second_value = msg_ok ? msg.second : 8'd0;
      rsp.day_value    = msg_ok ? msg.day    : 8'd0;
      rsp.month_value  = msg_ok ? msg.month  : 8'd0;
      rsp.year_value   = msg_ok ? msg.year   : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         save_cd_ff <= SAVE_RELOAD_RST;
         link_cd_ff <= {7'd0, LINK_IDLE_RST};
         status_ff  <= SYNC_RED;
         link_ff    <= 1'b0;
         health_ff  <= '0;
      end else if (step) begin
         save_cd_ff <= save_cd_in;
         link_cd_ff <= link_cd_in;
         status_ff  <= status_in;
         link_ff    <= link_in;
         health_ff  <= health_in;
      end
   end

   a_link_follows_status: assert property (@(posedge clock) disable iff (reset)
      !link_ff |-> status_ff == SYNC_RED)
      else $error("link down while sync not red");

   a_tick_no_msg: assert property (@(posedge clock) disable iff (reset)
      (step && op) |-> !msg_ok && !rtc)
      else $error("tick produced message result");

   a_msg_loads_timeout: assert property (@(posedge clock) disable iff (reset)
      (step && msg_ok) |=> link_cd_ff == $past(cfg.link_timeout_reload) && link_ff)
      else $error("link timeout not reloaded on message");

endmodule

/* hdl/time_sync_message_monitor.sv */
// Top level of the time sync message monitor: configuration registers,
// input register, result register and handshakes. Depends on tsm_pkg,
// tsm_store and tsm_core.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_op, req_msg_byte, req_msg_last
//   rsp      out        rsp_valid / rsp_ready  rsp_lock_state ... rsp_year_value
//   csr      in         csr_wr_en              csr_index, csr_wdata
//
// One item per cycle sustained while the result register is not stalled by rsp_ready;
// an accepted item passes the input register, then store/decode/state logic, then the result register.
// Reset clears control state, the byte store and loads register defaults.
// A stalled result holds the pipeline; req_ready drops only when both stages are full.
module time_sync_message_monitor #(
   parameter int MESSAGE_BYTES = tsm_pkg::MESSAGE_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_op,
   input  logic [7:0]                      req_msg_byte,
   input  logic                            req_msg_last,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_lock_state,
   output logic                            rsp_link_up,
   output logic                            rsp_message_ok,
   output logic [3:0]                      rsp_health_flags,
   output logic                            rsp_rtc_write,
   output logic [7:0]                      rsp_hour_value,
   output logic [7:0]                      rsp_minute_value,
   output logic [7:0]                      rsp_second_value,
   output logic [7:0]                      rsp_day_value,
   output logic [7:0]                      rsp_month_value,
   output logic [7:0]                      rsp_year_value,
   input  logic                            csr_wr_en,
   input  logic [1:0]                      csr_index,
   input  logic [tsm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tsm_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       in_valid_ff, in_valid_in;
   logic       op_ff;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;
   msg_type    msg;
   logic       advance;
   logic       step;
   logic       req_take;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign step      = in_valid_ff && advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SAVE_RELOAD:      cfg_in.save_reload         = csr_wdata[7:0];
            CSR_SAVE_READY_LEVEL: cfg_in.save_ready_level    = csr_wdata[7:0];
            CSR_LINK_RELOAD:      cfg_in.link_timeout_reload = csr_wdata[7:0];
            CSR_LINK_IDLE:        cfg_in.link_idle_value     = csr_wdata[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.save_reload         <= SAVE_RELOAD_RST;
         cfg_ff.save_ready_level    <= SAVE_READY_LEVEL_RST;
         cfg_ff.link_timeout_reload <= LINK_RELOAD_RST;
         cfg_ff.link_idle_value     <= LINK_IDLE_RST;
         in_valid_ff                <= 1'b0;
         rsp_valid_ff               <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff   <= req_op;
         byte_ff <= req_msg_byte;
         last_ff <= req_msg_last;
      end
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   tsm_store #(
      .MESSAGE_BYTES (MESSAGE_BYTES)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .op       (op_ff),
      .msg_byte (byte_ff),
      .msg_last (last_ff),
      .msg      (msg)
   );

   tsm_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .op       (op_ff),
      .msg_last (last_ff),
      .msg      (msg),
      .cfg      (cfg_ff),
      .rsp      (rsp_in)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_lock_state   = rsp_ff.lock_state;
   assign rsp_link_up      = rsp_ff.link_up;
   assign rsp_message_ok   = rsp_ff.message_ok;
   assign rsp_health_flags = rsp_ff.health_flags;
   assign rsp_rtc_write    = rsp_ff.rtc_write;
   assign rsp_hour_value   = rsp_ff.hour_value;
   assign rsp_minute_value = rsp_ff.minute_value;
   assign rsp_second_value = rsp_ff.second_value;
   assign rsp_day_value    = rsp_ff.day_value;
   assign rsp_month_value  = rsp_ff.month_value;
   assign rsp_year_value   = rsp_ff.year_value;

   a_rtc_needs_msg: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rtc_write) |-> rsp_message_ok)
      else $error("rtc write without valid message");

   a_msg_sets_link: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_message_ok) |-> rsp_link_up && rsp_lock_state != SYNC_RED)
      else $error("valid message left link down");

   a_no_time_without_msg: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_message_ok) |-> rsp_hour_value == 8'd0 &&
                                         rsp_second_value == 8'd0 && !rsp_rtc_write)
      else $error("time fields set without message");

   a_step_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("processed item lost");

endmodule
